@@ rtl/core/pek_pkg.sv @@
`timescale 1ns / 1ps

package pek_pkg;

    // Configuration register map
    localparam int CFG_ADDR_W = 8;
    localparam logic [CFG_ADDR_W-1:0] REG_EARTH_VEL_X = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_EARTH_VEL_Y = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_EARTH_VEL_Z = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RING_COUNT  = 8'd3;

    // Pipeline geometry
    localparam int FRONT_STAGES = 6;
    localparam int SQRT_STAGES  = 64;
    localparam int CORDIC_ITERS = 31;
    localparam int RING_SIDE_N  = CORDIC_ITERS + 4;
    localparam int NORM_LEN     = 39;
    localparam int CW           = 44;
    localparam int ZW           = 34;

    // Angle scale: pi is 2^31
    localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_ITERS] = '{
        34'sh20000000, 34'sh12E4051E, 34'sh09FB385B, 34'sh051111D4, 34'sh028B0D43,
        34'sh0145D7E1, 34'sh00A2F61E, 34'sh00517C55, 34'sh0028BE53, 34'sh00145F2F,
        34'sh000A2F98, 34'sh000517CC, 34'sh00028BE6, 34'sh000145F3, 34'sh0000A2FA,
        34'sh0000517D, 34'sh000028BE, 34'sh0000145F, 34'sh00000A30, 34'sh00000518,
        34'sh0000028C, 34'sh00000146, 34'sh000000A3, 34'sh00000051, 34'sh00000029,
        34'sh00000014, 34'sh0000000A, 34'sh00000005, 34'sh00000003, 34'sh00000001,
        34'sh00000001
    };

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
    } pek_in_t;

    typedef struct packed {
        logic [31:0] radius;
        logic [31:0] speed;
        logic [31:0] ang_momentum;
        logic [7:0]  ring_index;
        logic        degenerate;
    } pek_out_t;

    // Side data riding along the square-root pipeline
    typedef struct packed {
        logic [63:0] cm;
        logic        cneg;
        logic        degen;
        logic [8:0]  ring_n;
    } sq_tag_t;

    // Side data riding along the ring pipeline
    typedef struct packed {
        logic        degen;
        logic [8:0]  ring_n;
        logic [31:0] radius;
        logic [31:0] speed;
        logic [31:0] ang_momentum;
    } ring_side_t;

    typedef struct packed {
        logic [63:0] cm;
        logic        cneg;
        logic [63:0] s;
        ring_side_t  side;
    } ring_in_t;

endpackage

@@ rtl/core/pek_isqrt.sv @@
`timescale 1ns / 1ps

module pek_isqrt (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [127:0]      in_rad,
    input  pek_pkg::sq_tag_t  in_tag,
    output logic              out_valid,
    output logic [63:0]       out_root,
    output pek_pkg::sq_tag_t  out_tag
);
    import pek_pkg::*;

    logic [65:0]            rem_reg  [SQRT_STAGES];
    logic [63:0]            root_reg [SQRT_STAGES];
    logic [127:0]           rad_reg  [SQRT_STAGES];
    sq_tag_t                tag_reg  [SQRT_STAGES];
    logic [SQRT_STAGES-1:0] valid_reg;

    logic [65:0]  rem_next  [SQRT_STAGES];
    logic [63:0]  root_next [SQRT_STAGES];
    logic [127:0] rad_next  [SQRT_STAGES];

    // One result bit per stage, restoring digit recurrence
    genvar k;
    generate
        for (k = 0; k < SQRT_STAGES; k++) begin : g_step
            logic [65:0]  rem_src;
            logic [63:0]  root_src;
            logic [127:0] rad_src;
            logic [67:0]  part;
            logic [67:0]  trial;
            logic         take;
            if (k == 0) begin : g_first
                assign rem_src  = '0;
                assign root_src = '0;
                assign rad_src  = in_rad;
            end else begin : g_next
                assign rem_src  = rem_reg[k-1];
                assign root_src = root_reg[k-1];
                assign rad_src  = rad_reg[k-1];
            end
            assign part         = {rem_src, rad_src[127:126]};
            assign trial        = {2'b00, root_src, 2'b01};
            assign take         = (part >= trial);
            assign rem_next[k]  = take ? 66'(part - trial) : part[65:0];
            assign root_next[k] = {root_src[62:0], take};
            assign rad_next[k]  = {rad_src[125:0], 2'b00};
        end
    endgenerate

    // Advance the data stages
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < SQRT_STAGES; i++) begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                rad_reg[i]  <= rad_next[i];
            end
            tag_reg[0] <= in_tag;
            for (int i = 1; i < SQRT_STAGES; i++) begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    // Advance the valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[SQRT_STAGES-2:0], in_valid};
        end
    end

    assign out_valid = valid_reg[SQRT_STAGES-1];
    assign out_root  = root_reg[SQRT_STAGES-1];
    assign out_tag   = tag_reg[SQRT_STAGES-1];

endmodule

@@ rtl/core/pek_ring.sv @@
`timescale 1ns / 1ps

module pek_ring (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  pek_pkg::ring_in_t  in_data,
    output logic               out_valid,
    output pek_pkg::pek_out_t  out_data
);
    import pek_pkg::*;

    logic [RING_SIDE_N-1:0] valid_reg;
    ring_side_t             side_reg [RING_SIDE_N];
    logic                   out_valid_reg;
    pek_out_t               out_reg;

    // Stage A: larger magnitude and its bit length
    logic [63:0] m_val;
    logic [6:0]  len_val;
    logic [63:0] a_cm_reg, a_s_reg;
    logic [6:0]  a_len_reg;
    logic        a_cneg_reg;

    always_comb begin
        m_val   = (in_data.cm > in_data.s) ? in_data.cm : in_data.s;
        len_val = '0;
        for (int i = 0; i < 64; i++) begin
            if (m_val[i]) len_val = 7'(i + 1);
        end
    end

    // Stage B: normalise both to a fixed bit length
    logic [NORM_LEN-1:0] b_cm_next, b_s_next, b_cm_reg, b_s_reg;
    logic                b_cneg_reg;

    always_comb begin
        if (a_len_reg > 7'(NORM_LEN)) begin
            b_cm_next = NORM_LEN'(a_cm_reg >> (a_len_reg - 7'(NORM_LEN)));
            b_s_next  = NORM_LEN'(a_s_reg >> (a_len_reg - 7'(NORM_LEN)));
        end else begin
            b_cm_next = NORM_LEN'(a_cm_reg << (7'(NORM_LEN) - a_len_reg));
            b_s_next  = NORM_LEN'(a_s_reg << (7'(NORM_LEN) - a_len_reg));
        end
    end

    // Stage C: fold the left half-plane onto the right
    logic signed [CW-1:0] c_x_reg, c_y_reg;
    logic signed [ZW-1:0] c_z_reg;
    logic                 c_fold;

    // A negative dot product truncated to zero stays on the right half-plane
    assign c_fold = b_cneg_reg && (b_cm_reg != '0);

    // CORDIC vectoring iterations
    logic signed [CW-1:0] x_reg [CORDIC_ITERS];
    logic signed [CW-1:0] y_reg [CORDIC_ITERS];
    logic signed [ZW-1:0] z_reg [CORDIC_ITERS];
    logic signed [CW-1:0] x_next [CORDIC_ITERS];
    logic signed [CW-1:0] y_next [CORDIC_ITERS];
    logic signed [ZW-1:0] z_next [CORDIC_ITERS];

    genvar k;
    generate
        for (k = 0; k < CORDIC_ITERS; k++) begin : g_iter
            logic signed [CW-1:0] xs, ys;
            logic signed [ZW-1:0] zs;
            if (k == 0) begin : g_first
                assign xs = c_x_reg;
                assign ys = c_y_reg;
                assign zs = c_z_reg;
            end else begin : g_next
                assign xs = x_reg[k-1];
                assign ys = y_reg[k-1];
                assign zs = z_reg[k-1];
            end
            assign x_next[k] = ys[CW-1] ? xs - (ys >>> k) : xs + (ys >>> k);
            assign y_next[k] = ys[CW-1] ? ys + (xs >>> k) : ys - (xs >>> k);
            assign z_next[k] = ys[CW-1] ? zs - ATAN_TAB[k] : zs + ATAN_TAB[k];
        end
    endgenerate

    // Stage D: clamp the angle and scale by the ring count
    logic signed [ZW-1:0] z_fin;
    logic [31:0]          zc;
    logic [40:0]          prod;
    logic [9:0]           d_q_reg;
    ring_side_t           d_side;

    assign z_fin  = z_reg[CORDIC_ITERS-1];
    assign d_side = side_reg[RING_SIDE_N-2];

    always_comb begin
        if (z_fin[ZW-1]) begin
            zc = '0;
        end else if (z_fin > (ZW'(1) <<< 31)) begin
            zc = 32'h8000_0000;
        end else begin
            zc = z_fin[31:0];
        end
    end

    assign prod = {9'b0, zc} * {32'b0, d_side.ring_n};

    // Stage E: limit to the last ring and build the output word
    ring_side_t  e_side;
    logic [8:0]  ring_lim;

    assign e_side   = side_reg[RING_SIDE_N-1];
    assign ring_lim = (d_q_reg >= {1'b0, e_side.ring_n}) ? (e_side.ring_n - 9'd1)
                                                       : d_q_reg[8:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            a_cm_reg   <= in_data.cm;
            a_s_reg    <= in_data.s;
            a_len_reg  <= len_val;
            a_cneg_reg <= in_data.cneg;

            b_cm_reg   <= b_cm_next;
            b_s_reg    <= b_s_next;
            b_cneg_reg <= a_cneg_reg;

            c_x_reg <= c_fold ? CW'({1'b0, b_s_reg}) : CW'({1'b0, b_cm_reg});
            c_y_reg <= c_fold ? CW'({1'b0, b_cm_reg}) : CW'({1'b0, b_s_reg});
            c_z_reg <= c_fold ? (ZW'(1) <<< 30) : '0;

            for (int i = 0; i < CORDIC_ITERS; i++) begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                z_reg[i] <= z_next[i];
            end

            d_q_reg <= prod[40:31];

            side_reg[0] <= in_data.side;
            for (int i = 1; i < RING_SIDE_N; i++) begin
                side_reg[i] <= side_reg[i-1];
            end

            out_reg.radius       <= e_side.radius;
            out_reg.speed        <= e_side.speed;
            out_reg.ang_momentum <= e_side.ang_momentum;
            out_reg.degenerate   <= e_side.degen;
            out_reg.ring_index   <= e_side.degen ? 8'd0 : ring_lim[7:0];
        end
    end

    // Advance the valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg     <= {valid_reg[RING_SIDE_N-2:0], in_valid};
            out_valid_reg <= valid_reg[RING_SIDE_N-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ rtl/core/particle_event_kinematics.sv @@
`timescale 1ns / 1ps
// Pipeline: 6 product/sum stages, 64 square-root stages and 36 ring stages
// lie between an accepted input word and its result word.
// Throughput: one word per cycle; the whole pipeline holds while the result waits.
// Reset: aresetn, synchronous, active low; clears all valid bits, earth velocity
// to zero and ring count to one.

module particle_event_kinematics (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  pek_pkg::pek_in_t                   s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output pek_pkg::pek_out_t                  m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pek_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [31:0]                        cfg_wdata
);
    import pek_pkg::*;

    // Configuration registers
    logic signed [31:0] evx_reg, evy_reg, evz_reg;
    logic [8:0]         rc_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            evx_reg <= '0;
            evy_reg <= '0;
            evz_reg <= '0;
            rc_reg  <= 9'd1;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_EARTH_VEL_X: evx_reg <= cfg_wdata;
                REG_EARTH_VEL_Y: evy_reg <= cfg_wdata;
                REG_EARTH_VEL_Z: evz_reg <= cfg_wdata;
                REG_RING_COUNT:  rc_reg  <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    // Global advance: hold every pipeline stage while the result word is stalled
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    logic signed [31:0] p [3];
    logic signed [31:0] v [3];
    logic signed [31:0] e [3];
    logic [8:0]         n_eff;
    logic               deg_in;

    assign p[0] = s_data.pos_x;
    assign p[1] = s_data.pos_y;
    assign p[2] = s_data.pos_z;
    assign v[0] = s_data.vel_x;
    assign v[1] = s_data.vel_y;
    assign v[2] = s_data.vel_z;
    assign e[0] = evx_reg;
    assign e[1] = evy_reg;
    assign e[2] = evz_reg;

    assign n_eff  = (rc_reg == 9'd0) ? 9'd1 : ((rc_reg > 9'd256) ? 9'd256 : rc_reg);
    assign deg_in = (p[0] == 0 && p[1] == 0 && p[2] == 0) ||
                    (e[0] == 0 && e[1] == 0 && e[2] == 0);

    logic [FRONT_STAGES-1:0] v_reg;

    // Stage 1 registers: all component products
    logic signed [63:0] s1_pp [3];
    logic signed [63:0] s1_vv [3];
    logic signed [63:0] s1_pv [6];
    logic signed [63:0] s1_pe [6];
    logic signed [63:0] s1_dot [3];
    logic               s1_deg;
    logic [8:0]         s1_n;

    // Stage 2 registers: sums and cross components
    logic [63:0]        s2_psum, s2_vsum;
    logic signed [63:0] s2_cr [6];
    logic signed [65:0] s2_dot;
    logic               s2_deg;
    logic [8:0]         s2_n;

    // Stage 3 registers: magnitudes
    logic [63:0] s3_psum, s3_vsum;
    logic [63:0] s3_mag [6];
    logic [63:0] s3_cm;
    logic        s3_cneg, s3_deg;
    logic [8:0]  s3_n;

    // Stage 4 registers: partial products of the squares
    logic [63:0] s4_psum, s4_vsum;
    logic [63:0] s4_hh [6];
    logic [63:0] s4_hl [6];
    logic [63:0] s4_ll [6];
    sq_tag_t     s4_tag;

    // Stage 5 registers: assembled squares
    logic [63:0]  s5_psum, s5_vsum;
    logic [127:0] s5_sq [6];
    sq_tag_t      s5_tag;

    // Stage 6 registers: radicands
    logic [63:0]  s6_psum, s6_vsum;
    logic [127:0] s6_rpv, s6_rpe;
    sq_tag_t      s6_tag;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                s1_pp[i]  <= p[i] * p[i];
                s1_vv[i]  <= v[i] * v[i];
                s1_dot[i] <= p[i] * e[i];
            end
            s1_pv[0] <= p[1] * v[2];
            s1_pv[1] <= p[2] * v[1];
            s1_pv[2] <= p[2] * v[0];
            s1_pv[3] <= p[0] * v[2];
            s1_pv[4] <= p[0] * v[1];
            s1_pv[5] <= p[1] * v[0];
            s1_pe[0] <= p[1] * e[2];
            s1_pe[1] <= p[2] * e[1];
            s1_pe[2] <= p[2] * e[0];
            s1_pe[3] <= p[0] * e[2];
            s1_pe[4] <= p[0] * e[1];
            s1_pe[5] <= p[1] * e[0];
            s1_deg   <= deg_in;
            s1_n     <= n_eff;

            s2_psum <= 64'(s1_pp[0]) + 64'(s1_pp[1]) + 64'(s1_pp[2]);
            s2_vsum <= 64'(s1_vv[0]) + 64'(s1_vv[1]) + 64'(s1_vv[2]);
            for (int i = 0; i < 3; i++) begin
                s2_cr[i]     <= s1_pv[2*i] - s1_pv[2*i+1];
                s2_cr[3 + i] <= s1_pe[2*i] - s1_pe[2*i+1];
            end
            s2_dot <= 66'(s1_dot[0]) + 66'(s1_dot[1]) + 66'(s1_dot[2]);
            s2_deg <= s1_deg;
            s2_n   <= s1_n;

            s3_psum <= s2_psum;
            s3_vsum <= s2_vsum;
            for (int i = 0; i < 6; i++) begin
                s3_mag[i] <= s2_cr[i][63] ? 64'(-s2_cr[i]) : 64'(s2_cr[i]);
            end
            s3_cm   <= s2_dot[65] ? 64'(-s2_dot) : s2_dot[63:0];
            s3_cneg <= s2_dot[65];
            s3_deg  <= s2_deg;
            s3_n    <= s2_n;

            s4_psum <= s3_psum;
            s4_vsum <= s3_vsum;
            for (int i = 0; i < 6; i++) begin
                s4_hh[i] <= s3_mag[i][63:32] * s3_mag[i][63:32];
                s4_hl[i] <= s3_mag[i][63:32] * s3_mag[i][31:0];
                s4_ll[i] <= s3_mag[i][31:0] * s3_mag[i][31:0];
            end
            s4_tag.cm     <= s3_cm;
            s4_tag.cneg   <= s3_cneg;
            s4_tag.degen  <= s3_deg;
            s4_tag.ring_n <= s3_n;

            s5_psum <= s4_psum;
            s5_vsum <= s4_vsum;
            for (int i = 0; i < 6; i++) begin
                s5_sq[i] <= {s4_hh[i], 64'b0} + {31'b0, s4_hl[i], 33'b0} +
                            {64'b0, s4_ll[i]};
            end
            s5_tag <= s4_tag;

            s6_psum <= s5_psum;
            s6_vsum <= s5_vsum;
            s6_rpv  <= s5_sq[0] + s5_sq[1] + s5_sq[2];
            s6_rpe  <= s5_sq[3] + s5_sq[4] + s5_sq[5];
            s6_tag  <= s5_tag;
        end
    end

    // Advance the front valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[FRONT_STAGES-2:0], s_valid};
        end
    end

    // Four square roots in lockstep; the first carries valid and side data
    logic        sq_valid;
    sq_tag_t     sq_tag;
    logic [63:0] root_p, root_v, root_pv, root_pe;

    pek_isqrt u_sqrt_p (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v_reg[FRONT_STAGES-1]), .in_rad({64'b0, s6_psum}), .in_tag(s6_tag),
        .out_valid(sq_valid), .out_root(root_p), .out_tag(sq_tag)
    );

    pek_isqrt u_sqrt_v (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v_reg[FRONT_STAGES-1]), .in_rad({64'b0, s6_vsum}), .in_tag('0),
        .out_valid(), .out_root(root_v), .out_tag()
    );

    pek_isqrt u_sqrt_pv (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v_reg[FRONT_STAGES-1]), .in_rad(s6_rpv), .in_tag('0),
        .out_valid(), .out_root(root_pv), .out_tag()
    );

    pek_isqrt u_sqrt_pe (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(v_reg[FRONT_STAGES-1]), .in_rad(s6_rpe), .in_tag('0),
        .out_valid(), .out_root(root_pe), .out_tag()
    );

    // Saturate the angular momentum norm and hand over to the ring pipeline
    ring_in_t ring_in;

    always_comb begin
        ring_in.cm                = sq_tag.cm;
        ring_in.cneg              = sq_tag.cneg;
        ring_in.s                 = root_pe;
        ring_in.side.degen        = sq_tag.degen;
        ring_in.side.ring_n       = sq_tag.ring_n;
        ring_in.side.radius       = root_p[31:0];
        ring_in.side.speed        = root_v[31:0];
        ring_in.side.ang_momentum = (root_pv[63:48] != 16'd0) ? 32'hFFFF_FFFF
                                                               : root_pv[47:16];
    end

    pek_ring u_ring (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(sq_valid), .in_data(ring_in),
        .out_valid(m_valid), .out_data(m_data)
    );

    // A degenerate word always reports the first ring
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.degenerate |-> m_data.ring_index == 8'd0)
        else $error("degenerate word with nonzero ring index");

    // Reset empties the pipeline
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid straight after reset");

endmodule

@@ test/particle_event_kinematics_test.sv @@
`timescale 1ns / 1ps

module particle_event_kinematics_test;
    import pek_pkg::*;

    localparam int LATENCY_WAIT = 120;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RAND_PER_SET = 190;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    pek_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    pek_out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;

    // Shadow of the block's registers
    logic signed [31:0] earth_x = '0, earth_y = '0, earth_z = '0;
    logic [8:0] rings = 9'd1;

    pek_in_t pending_words[$];
    pek_out_t expected_words[$];
    int send_gap = 0;
    int recv_stall = 0;
    int mismatches = 0;
    int cycles = 0;

    particle_event_kinematics uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Exact floor square root of a 128-bit sum of squares
    function automatic logic [63:0] vec_length(logic signed [65:0] a, logic signed [65:0] b,
                                               logic signed [65:0] c);
        logic [63:0] ma, mb, mc, root, trial;
        logic [127:0] sum;
        ma = (a < 0) ? 64'(-a) : 64'(a);
        mb = (b < 0) ? 64'(-b) : 64'(b);
        mc = (c < 0) ? 64'(-c) : 64'(c);
        sum = {64'd0, ma} * {64'd0, ma} + {64'd0, mb} * {64'd0, mb}
            + {64'd0, mc} * {64'd0, mc};
        root = '0;
        for (int b2 = 63; b2 >= 0; b2--) begin
            trial = root | (64'd1 << b2);
            if ({64'd0, trial} * {64'd0, trial} <= sum) root = trial;
        end
        return root;
    endfunction

    function automatic logic [31:0] saturate32(logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // Angle by CORDIC vectoring, then bin into n rings over [0, pi]
    function automatic logic [7:0] ring_bin(logic neg, logic [63:0] cm, logic [63:0] s,
                                            int unsigned n);
        logic [63:0] m, rv;
        int len;
        longint x, y, z, dx, dy, t;
        m = (cm > s) ? cm : s;
        len = 0;
        while (len < 64 && (m >> len) != 0) len++;
        if (len > NORM_LEN) begin
            cm = cm >> (len - NORM_LEN);
            s = s >> (len - NORM_LEN);
        end else begin
            cm = cm << (NORM_LEN - len);
            s = s << (NORM_LEN - len);
        end
        x = neg ? -longint'(cm) : longint'(cm);
        y = longint'(s);
        z = 0;
        if (x < 0) begin
            t = y;
            y = -x;
            x = t;
            z = longint'(1) << 30;
        end
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end else begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end
        end
        if (z < 0) z = 0;
        if (z > (longint'(1) << 31)) z = longint'(1) << 31;
        rv = (64'(z) * 64'(n)) >> 31;
        if (rv >= n) rv = n - 1;
        return rv[7:0];
    endfunction

    function automatic pek_out_t predict_kinematics(pek_in_t w);
        longint p0, p1, p2, v0, v1, v2, e0, e1, e2;
        logic signed [65:0] dot;
        logic [63:0] s;
        int unsigned n;
        pek_out_t r;
        p0 = w.pos_x; p1 = w.pos_y; p2 = w.pos_z;
        v0 = w.vel_x; v1 = w.vel_y; v2 = w.vel_z;
        e0 = earth_x; e1 = earth_y; e2 = earth_z;
        r.radius = saturate32(vec_length(66'(p0), 66'(p1), 66'(p2)));
        r.speed = saturate32(vec_length(66'(v0), 66'(v1), 66'(v2)));
        r.ang_momentum = saturate32(vec_length(66'(p1 * v2) - 66'(p2 * v1),
                                               66'(p2 * v0) - 66'(p0 * v2),
                                               66'(p0 * v1) - 66'(p1 * v0)) >> 16);
        r.degenerate = (p0 == 0 && p1 == 0 && p2 == 0) || (e0 == 0 && e1 == 0 && e2 == 0);
        r.ring_index = '0;
        if (!r.degenerate) begin
            s = vec_length(66'(p1 * e2) - 66'(p2 * e1), 66'(p2 * e0) - 66'(p0 * e2),
                           66'(p0 * e1) - 66'(p1 * e0));
            dot = 66'(p0 * e0) + 66'(p1 * e1) + 66'(p2 * e2);
            n = (rings == 0) ? 1 : (rings > 256) ? 256 : rings;
            r.ring_index = ring_bin(dot < 0, (dot < 0) ? 64'(-dot) : 64'(dot), s, n);
        end
        return r;
    endfunction

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch on %s: got %h, expected %h at %0t", field, got, want, $realtime);
        mismatches++;
    endtask

    // Input side: hold until accepted, then idle or load the next word
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !s_ready)) begin
            if (s_valid) expected_words.push_back(predict_kinematics(s_data));
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                s_data <= pending_words.pop_front();
                s_valid <= 1'b1;
                send_gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 12);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side: check each accepted word, stall at random
    always @(posedge aclk) begin
        pek_out_t want;
        int stall;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $display("unexpected result word at %0t", $realtime);
                    mismatches++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_data.radius !== want.radius)
                        report("radius", m_data.radius, want.radius);
                    if (m_data.speed !== want.speed)
                        report("speed", m_data.speed, want.speed);
                    if (m_data.ang_momentum !== want.ang_momentum)
                        report("ang_momentum", m_data.ang_momentum, want.ang_momentum);
                    if (m_data.ring_index !== want.ring_index)
                        report("ring_index", 32'(m_data.ring_index), 32'(want.ring_index));
                    if (m_data.degenerate !== want.degenerate)
                        report("degenerate", 32'(m_data.degenerate), 32'(want.degenerate));
                end
                stall = $urandom_range(0, 1) ? 0 : $urandom_range(0, 12);
                recv_stall <= (stall > 0) ? stall - 1 : 0;
                m_ready <= (stall == 0);
            end else if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Guard against a hang
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** particle_event_kinematics: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [31:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (addr)
            REG_EARTH_VEL_X: earth_x = value;
            REG_EARTH_VEL_Y: earth_y = value;
            REG_EARTH_VEL_Z: earth_z = value;
            REG_RING_COUNT:  rings = value[8:0];
            default: ;
        endcase
    endtask

    task automatic set_earth(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [31:0] n);
        write_reg(REG_EARTH_VEL_X, x);
        write_reg(REG_EARTH_VEL_Y, y);
        write_reg(REG_EARTH_VEL_Z, z);
        write_reg(REG_RING_COUNT, n);
    endtask

    task automatic queue_word(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
        pek_in_t w;
        w = {px, py, pz, vx, vy, vz};
        pending_words.push_back(w);
    endtask

    function automatic logic [31:0] random_comp();
        case ($urandom_range(0, 5))
            0, 1, 2: return $urandom;
            3: return 32'($urandom_range(0, 4000)) - 32'd2000;
            4: case ($urandom_range(0, 4))
                   0: return 32'h8000_0000;
                   1: return 32'h7FFF_FFFF;
                   2: return 32'hFFFF_FFFF;
                   3: return 32'd1;
                   default: return 32'd0;
               endcase
            default: return $urandom_range(0, 1) ? ($urandom >> $urandom_range(0, 31))
                                                 : -($urandom >> $urandom_range(0, 31));
        endcase
    endfunction

    // Mostly random vectors; some lie along the earth velocity to reach the angle ends
    task automatic queue_random(int count);
        int sh;
        logic [31:0] px, py, pz;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                sh = $urandom_range(0, 20);
                px = earth_x >>> sh; py = earth_y >>> sh; pz = earth_z >>> sh;
                if ($urandom_range(0, 1)) begin
                    px = -px; py = -py; pz = -pz;
                end
            end else begin
                px = random_comp(); py = random_comp(); pz = random_comp();
            end
            queue_word(px, py, pz, random_comp(), random_comp(), random_comp());
        end
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || s_valid || expected_words.size() > 0)
            @(posedge aclk);
        repeat (LATENCY_WAIT) @(posedge aclk);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Earth velocity still zero after reset: every word is degenerate
        queue_word(0, 0, 0, 0, 0, 0);
        queue_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_word(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0);
        queue_random(RAND_PER_SET);
        drain();

        // Unit earth velocity along x, finest rings
        set_earth(32'h0001_0000, 0, 0, 256);
        queue_word(32'h0003_0000, 0, 0, 1, 2, 3);
        queue_word(32'hFFFD_0000, 0, 0, 1, 2, 3);
        queue_word(0, 32'h0002_0000, 0, 0, 0, 0);
        queue_word(0, 0, 0, 5, 5, 5);
        queue_word(1, 0, 0, 0, 0, 0);
        queue_word(32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        queue_word(32'h8000_0000, 0, 0, 0, 0, 0);
        queue_word(32'h7FFF_FFFF, 1, 0, 0, 0, 0);
        queue_word(32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0);
        queue_word(32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0);
        queue_random(RAND_PER_SET);
        drain();

        // Extreme earth velocity, a single ring
        set_earth(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1);
        queue_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);
        queue_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0);
        queue_random(RAND_PER_SET);
        drain();

        // Ring count of zero acts as one; an unknown index is ignored
        set_earth(0, 32'hFFFF_FFFF, 0, 0);
        write_reg(CFG_ADDR_W'(4), 32'h0000_0007);
        write_reg(CFG_ADDR_W'(255), $urandom);
        queue_word(0, 32'h0001_0000, 0, 0, 0, 0);
        queue_word(0, 32'hFFFF_0000, 0, 0, 0, 0);
        queue_random(RAND_PER_SET);
        drain();

        // Ring count above the maximum acts as the maximum
        set_earth(0, 0, 32'h7FFF_FFFF, 32'h1FF);
        queue_word(0, 0, 32'hFFFF_FFFF, 0, 0, 0);
        queue_random(RAND_PER_SET);
        drain();

        // Random settings
        for (int k = 0; k < 3; k++) begin
            set_earth(random_comp(), random_comp(), random_comp(),
                      $urandom_range(1, 256) | ($urandom & 32'hFFFF_FE00));
            queue_random(70);
            drain();
        end

        if (mismatches == 0) begin
            $display("** particle_event_kinematics: PASSED **");
        end else begin
            $display("** particle_event_kinematics: FAILED **");
        end
        $finish;
    end

endmodule

@@ particle_event_kinematics.f @@
rtl/core/pek_pkg.sv
rtl/core/pek_isqrt.sv
rtl/core/pek_ring.sv
rtl/core/particle_event_kinematics.sv
test/particle_event_kinematics_test.sv
